FILE: src/egr_pkg.sv
// Shared constants, types and the gradient scaling function for the edge gradient block.
package egr_pkg;

	localparam int DEF_MAX_WIDTH = 4096;
	localparam int MAX_HEIGHT    = 4096;

	localparam int PIX_W  = 8;
	localparam int ROW_W  = 12;
	localparam int DIM_W  = 13;
	localparam int GAIN_W = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_Q8      = 2'd2;

	localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [GAIN_W-1:0] RST_GAIN_Q8      = 16'd256;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// flags worked out when a word is taken in, carried with it to the output register
	typedef struct packed {
		logic has_result;
		logic last;
	} egr_ctl_t;

	// |g| * gain in Q8.8, truncated and clamped to one pixel
	function automatic logic [PIX_W-1:0] scale_mag(input logic [9:0] mag,
			input logic [GAIN_W-1:0] gain);
		logic [25:0] prod;
		prod = 26'(mag) * 26'(gain);
		if (prod[25:16] != 10'd0)
			return PIX_MAX;
		else
			return prod[15:8];
	endfunction

endpackage

FILE: src/edge_gradient_3x3.sv
// Top level of the streaming 3x3 Prewitt edge magnitude block.
// Takes one pixel a clock in raster order and gives one edge magnitude for every
// interior pixel of the frame, none for the border; last_of_frame marks the result
// of the frame's final pixel. A word is taken in every cycle while the output is not
// stalled: the line-buffer read is registered with the word in the input stage, the
// kernel works between that stage and the output register, from which a result is
// offered. Column and row counters wrap at the end of a frame by themselves;
// frame_start forces the pixel to row 0, column 0. Line buffers need no clearing
// pass: rows are only read back after they were written in the frame.
// Write image_width, image_height and gain_q8 only while the block is idle.
module edge_gradient_3x3
	import egr_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_write,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIX_W-1:0]  pixel_value,
	input  logic              frame_start,

	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  edge_value,
	output logic              last_of_frame
);

	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int EW  = (WW > DIM_W) ? WW : DIM_W;
	localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_E = DIM_W'(MAX_HEIGHT);

	logic [DIM_W-1:0]  width_q, height_q;
	logic [GAIN_W-1:0] gain_q;

	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic             valid_s1;
	logic [AW-1:0]    col_s1;
	logic [PIX_W-1:0] pix_s1;
	egr_ctl_t         ctl_s1;

	logic             valid_s2;
	logic [PIX_W-1:0] edge_s2;
	logic             last_s2;

	logic             accept, advance;
	logic [EW-1:0]    w_eff, w_ext;
	logic [DIM_W-1:0] h_eff;
	logic [AW-1:0]    col;
	logic [ROW_W-1:0] row;
	logic             last_col, last_row;
	egr_ctl_t         ctl_in;
	logic [PIX_W-1:0] top, mid, edge_comb;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			gain_q   <= RST_GAIN_Q8;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_GAIN_Q8:      gain_q   <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// position of the incoming word and its flags
	always_comb begin
		w_ext = EW'(width_q);
		if (w_ext < EW'(3))
			w_eff = EW'(3);
		else if (w_ext > MAX_W_E)
			w_eff = MAX_W_E;
		else
			w_eff = w_ext;
		if (height_q < DIM_W'(3))
			h_eff = DIM_W'(3);
		else if (height_q > MAX_H_E)
			h_eff = MAX_H_E;
		else
			h_eff = height_q;

		col = frame_start ? '0 : col_q;
		row = frame_start ? '0 : row_q;
		last_col = EW'(col) >= w_eff - EW'(1);
		last_row = DIM_W'(row) >= h_eff - DIM_W'(1);
		ctl_in.has_result = (row >= ROW_W'(2)) && (EW'(col) >= EW'(2));
		ctl_in.last       = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row + 1'b1;
			end else begin
				col_q <= col + 1'b1;
				row_q <= row;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col;
			pix_s1 <= pixel_value;
			ctl_s1 <= ctl_in;
		end
	end

	// upper row takes over what the lower row held at this column
	egr_linebuf #(
		.DEPTH (MAX_WIDTH)
	) u_lb_upper (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (top),
		.wr_en   (advance),
		.wr_addr (col_s1),
		.wr_data (mid)
	);

	egr_linebuf #(
		.DEPTH (MAX_WIDTH)
	) u_lb_lower (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (mid),
		.wr_en   (advance),
		.wr_addr (col_s1),
		.wr_data (pix_s1)
	);

	egr_kernel u_kernel (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.top        (top),
		.mid        (mid),
		.pix        (pix_s1),
		.gain       (gain_q),
		.edge_value (edge_comb)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= ctl_s1.has_result;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			edge_s2 <= edge_comb;
			last_s2 <= ctl_s1.last;
		end
	end

	assign out_valid     = valid_s2;
	assign edge_value    = edge_s2;
	assign last_of_frame = last_s2;

endmodule

FILE: src/egr_linebuf.sv
// One line buffer: single-port-write memory with registered, write-first read.
module egr_linebuf
	import egr_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_WIDTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [PIX_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [PIX_W-1:0] wr_data
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// a write landing on the address being read wins
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr)
				rd_data_q <= wr_data;
			else
				rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/egr_kernel.sv
// 3x3 window registers, Prewitt gradients and the clamped magnitude sum.
module egr_kernel
	import egr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [PIX_W-1:0]  top,
	input  logic [PIX_W-1:0]  mid,
	input  logic [PIX_W-1:0]  pix,
	input  logic [GAIN_W-1:0] gain,
	output logic [PIX_W-1:0]  edge_value
);

	logic [PIX_W-1:0] win_q [6];

	logic [9:0]  sum_bot, sum_top, sum_rgt, sum_lft;
	logic [10:0] gv, gh;
	logic [9:0]  abs_v, abs_h;
	logic [PIX_W:0] total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (advance) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top;
			win_q[2] <= win_q[3];
			win_q[3] <= mid;
			win_q[4] <= win_q[5];
			win_q[5] <= pix;
		end
	end

	always_comb begin
		sum_bot = 10'(win_q[4]) + 10'(win_q[5]) + 10'(pix);
		sum_top = 10'(win_q[0]) + 10'(win_q[1]) + 10'(top);
		sum_rgt = 10'(top) + 10'(mid) + 10'(pix);
		sum_lft = 10'(win_q[0]) + 10'(win_q[2]) + 10'(win_q[4]);
		gv = 11'(sum_bot) - 11'(sum_top);
		gh = 11'(sum_rgt) - 11'(sum_lft);
		abs_v = gv[10] ? 10'(-gv) : gv[9:0];
		abs_h = gh[10] ? 10'(-gh) : gh[9:0];
		total = 9'(scale_mag(abs_v, gain)) + 9'(scale_mag(abs_h, gain));
		edge_value = total[PIX_W] ? PIX_MAX : total[PIX_W-1:0];
	end

endmodule

FILE: sim/tb_edge_gradient_3x3.sv
// Self-checking testbench for the streaming 3x3 Prewitt edge magnitude block.
`timescale 1ns / 1ps

module tb_edge_gradient_3x3;
	import egr_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] mag;
		logic             eof;
	} edge_res_t;

	// one line of the directed script: a register write or a pixel word
	typedef struct packed {
		bit               is_reg;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] val;
		logic [PIX_W-1:0] pix;
		logic             fs;
		bit               typed;
		edge_res_t        want;
	} step_t;

	typedef enum int {PIX_NOISE, PIX_EXTREME, PIX_SMOOTH} pix_mode_e;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write = 1'b0;
	logic [IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [PIX_W-1:0] pixel_value = '0;
	logic             frame_start = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [PIX_W-1:0] edge_value;
	logic             last_of_frame;

	edge_gradient_3x3 uut (
		.clk, .arst_n,
		.cfg_write, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .pixel_value, .frame_start,
		.out_valid, .out_stall, .edge_value, .last_of_frame
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#10_000_000;
		$display("tb_edge_gradient_3x3 failed");
		$finish;
	end

	// shadow of the block: registers, line buffers, window, position
	logic [DIM_W-1:0]  img_w = RST_IMAGE_WIDTH;
	logic [DIM_W-1:0]  img_h = RST_IMAGE_HEIGHT;
	logic [GAIN_W-1:0] gain = RST_GAIN_Q8;
	logic [PIX_W-1:0]  lb_upper [0:DEF_MAX_WIDTH-1];
	logic [PIX_W-1:0]  lb_lower [0:DEF_MAX_WIDTH-1];
	logic [PIX_W-1:0]  win [0:5];
	int                col_pos = 0;
	int                row_pos = 0;

	edge_res_t pending [$];
	step_t     script [$];
	int        bad_words = 0;
	int        drift = 128;
	bit        send_gaps = 1'b1;
	bit        stall_gaps = 1'b1;

	initial begin
		for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
			lb_upper[i] = '0;
			lb_lower[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			win[i] = '0;
	end

	function automatic int scaled_grad(input int g);
		longint a;
		longint m;
		a = (g < 0) ? -g : g;
		m = (a * longint'(gain)) >>> 8;
		return (m > 255) ? 255 : int'(m);
	endfunction

	task automatic prewitt_step(input logic [PIX_W-1:0] pix, input logic fs,
			output logic has, output edge_res_t res);
		int w, h, c, r, gv, gh, s;
		int t0, t1, t2, m0, m2, b0, b1, b2;
		logic [PIX_W-1:0] top, mid;
		w = (img_w < 3) ? 3 : ((img_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(img_w));
		h = (img_h < 3) ? 3 : ((img_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(img_h));
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		top = '0;
		mid = '0;
		if (c < DEF_MAX_WIDTH) begin
			top = lb_upper[c];
			mid = lb_lower[c];
			lb_upper[c] = mid;
			lb_lower[c] = pix;
		end
		has = (r >= 2 && c >= 2);
		res = '0;
		if (has) begin
			t0 = win[0]; t1 = win[1]; t2 = top;
			m0 = win[2]; m2 = mid;
			b0 = win[4]; b1 = win[5]; b2 = pix;
			gv = (b0 + b1 + b2) - (t0 + t1 + t2);
			gh = (t2 + m2 + b2) - (t0 + m0 + b0);
			s = scaled_grad(gv) + scaled_grad(gh);
			if (s > 255)
				s = 255;
			res.mag = s[PIX_W-1:0];
			res.eof = (r >= h - 1 && c >= w - 1);
		end
		win[0] = win[1]; win[1] = top;
		win[2] = win[3]; win[3] = mid;
		win[4] = win[5]; win[5] = pix;
		if (c >= w - 1) begin
			col_pos = 0;
			row_pos = (r >= h - 1) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs,
			input bit typed, input edge_res_t typed_res);
		logic has;
		edge_res_t res;
		@(negedge clk);
		while (send_gaps && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= pix;
		frame_start <= fs;
		do
			@(posedge clk);
		while (in_stall);
		prewitt_step(pix, fs, has, res);
		if (has)
			pending.push_back(typed ? typed_res : res);
	endtask

	// drop valid, wait for every expected word, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_IMAGE_WIDTH:  img_w = val[DIM_W-1:0];
			REG_IMAGE_HEIGHT: img_h = val[DIM_W-1:0];
			REG_GAIN_Q8:      gain = val[GAIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] next_pix(input pix_mode_e mode);
		int stp;
		case (mode)
			PIX_NOISE:   return PIX_W'($urandom_range(255));
			PIX_EXTREME: return $urandom_range(1) ? PIX_MAX : '0;
			default: begin
				stp = int'($urandom_range(8)) - 4;
				drift = drift + stp;
				if (drift < 0)
					drift = 0;
				if (drift > 255)
					drift = 255;
				return drift[PIX_W-1:0];
			end
		endcase
	endfunction

	function automatic step_t step_reg(input logic [IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		step_t st;
		st = '0;
		st.is_reg = 1'b1;
		st.idx = idx;
		st.val = val;
		return st;
	endfunction

	function automatic step_t step_px(input logic [PIX_W-1:0] pix, input logic fs);
		step_t st;
		st = '0;
		st.pix = pix;
		st.fs = fs;
		return st;
	endfunction

	function automatic step_t step_chk(input logic [PIX_W-1:0] pix, input logic fs,
			input logic [PIX_W-1:0] mag, input logic eof);
		step_t st;
		st = step_px(pix, fs);
		st.typed = 1'b1;
		st.want.mag = mag;
		st.want.eof = eof;
		return st;
	endfunction

	always @(negedge clk)
		out_stall <= stall_gaps && ($urandom_range(99) < 7);

	always @(posedge clk) begin : check_out
		edge_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				bad_words++;
				if (bad_words <= 10)
					$display("unexpected word: edge_value %0d last_of_frame %0b",
						edge_value, last_of_frame);
			end else begin
				want = pending.pop_front();
				if (edge_value !== want.mag || last_of_frame !== want.eof) begin
					bad_words++;
					if (bad_words <= 10)
						$display("mismatch: expected %0d/%0b, got %0d/%0b",
							want.mag, want.eof, edge_value, last_of_frame);
				end
			end
		end
	end

	initial begin : stimulus
		int n, k, sent;
		pix_mode_e mode;
		logic [CFG_W-1:0] w_set, h_set, g_set;

		// 3x3 frames: one interior result each, at the last pixel
		script.push_back(step_reg(REG_IMAGE_WIDTH, 16'd3));
		script.push_back(step_reg(REG_IMAGE_HEIGHT, 16'd3));
		// unit step on the right column at the reset gain
		script.push_back(step_px(8'd0, 1'b1)); script.push_back(step_px(8'd0, 1'b0));
		script.push_back(step_px(8'd1, 1'b0));
		script.push_back(step_px(8'd0, 1'b0)); script.push_back(step_px(8'd0, 1'b0));
		script.push_back(step_px(8'd1, 1'b0));
		script.push_back(step_px(8'd0, 1'b0)); script.push_back(step_px(8'd0, 1'b0));
		script.push_back(step_chk(8'd1, 1'b0, 8'd3, 1'b1));
		// full-scale bottom row at the largest gain; frame follows without frame_start
		script.push_back(step_reg(REG_GAIN_Q8, 16'hFFFF));
		script.push_back(step_px(8'd0, 1'b0)); script.push_back(step_px(8'd0, 1'b0));
		script.push_back(step_px(8'd0, 1'b0));
		script.push_back(step_px(8'd0, 1'b0)); script.push_back(step_px(8'd0, 1'b0));
		script.push_back(step_px(8'd0, 1'b0));
		script.push_back(step_px(8'd255, 1'b0)); script.push_back(step_px(8'd255, 1'b0));
		script.push_back(step_chk(8'd255, 1'b0, PIX_MAX, 1'b1));
		// checkerboard at zero gain
		script.push_back(step_reg(REG_GAIN_Q8, 16'd0));
		script.push_back(step_px(8'd255, 1'b1)); script.push_back(step_px(8'd0, 1'b0));
		script.push_back(step_px(8'd255, 1'b0));
		script.push_back(step_px(8'd0, 1'b0)); script.push_back(step_px(8'd255, 1'b0));
		script.push_back(step_px(8'd0, 1'b0));
		script.push_back(step_px(8'd255, 1'b0)); script.push_back(step_px(8'd0, 1'b0));
		script.push_back(step_chk(8'd255, 1'b0, 8'd0, 1'b1));

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset geometry: two rows of 640, then the start of the third
		for (int i = 0; i < 640 * 2 + 20; i++)
			send_pixel(next_pix(PIX_SMOOTH), 1'b0, 1'b0, '0);
		drain();

		foreach (script[i]) begin
			if (script[i].is_reg) begin
				drain();
				write_reg(script[i].idx, script[i].val);
			end else begin
				send_pixel(script[i].pix, script[i].fs, script[i].typed, script[i].want);
			end
		end
		drain();

		// width clamped from all ones, then height clamped likewise
		write_reg(REG_IMAGE_WIDTH, 16'h1FFF);
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		write_reg(REG_GAIN_Q8, 16'($urandom_range(16, 300)));
		for (int i = 0; i < 40; i++)
			send_pixel(next_pix(PIX_NOISE), i == 0, 1'b0, '0);
		drain();
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_IMAGE_HEIGHT, 16'h1FFF);
		for (int i = 0; i < 60; i++)
			send_pixel(next_pix(PIX_SMOOTH), i == 0, 1'b0, '0);
		drain();

		sent = 0;
		k = 0;
		while (sent < 260) begin
			case ($urandom_range(9))
				0:       w_set = 16'($urandom_range(2));
				1:       w_set = 16'($urandom_range(13, 40));
				default: w_set = 16'($urandom_range(3, 12));
			endcase
			h_set = ($urandom_range(9) == 0) ? 16'($urandom_range(2))
				: 16'($urandom_range(3, 8));
			case ($urandom_range(5))
				0:       g_set = 16'd0;
				1:       g_set = 16'hFFFF;
				2:       g_set = RST_GAIN_Q8;
				5:       g_set = 16'($urandom);
				default: g_set = 16'($urandom_range(1, 700));
			endcase
			write_reg(REG_IMAGE_WIDTH, w_set);
			write_reg(REG_IMAGE_HEIGHT, h_set);
			write_reg(REG_GAIN_Q8, g_set);
			mode = pix_mode_e'($urandom_range(2));
			// one long stretch with no gaps on either side
			if (k == 2) begin
				send_gaps = 1'b0;
				stall_gaps = 1'b0;
				n = 150;
			end else begin
				n = $urandom_range(30, 100);
			end
			for (int i = 0; i < n; i++)
				send_pixel(next_pix(mode), i == 0 || $urandom_range(99) < 2, 1'b0, '0);
			sent += n;
			drain();
			send_gaps = 1'b1;
			stall_gaps = 1'b1;
			k++;
		end

		// shrink the geometry mid-frame: the counter lands past the new last column
		write_reg(REG_IMAGE_WIDTH, 16'd10);
		write_reg(REG_IMAGE_HEIGHT, 16'd6);
		for (int i = 0; i < 38; i++)
			send_pixel(next_pix(PIX_NOISE), i == 0, 1'b0, '0);
		drain();
		write_reg(REG_IMAGE_WIDTH, 16'd5);
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		for (int i = 0; i < 40; i++)
			send_pixel(next_pix(PIX_NOISE), 1'b0, 1'b0, '0);
		drain();

		if (bad_words == 0)
			$display("tb_edge_gradient_3x3 passed");
		else
			$display("tb_edge_gradient_3x3 failed");
		$finish;
	end

endmodule
